// File: sv/neighbour_difference_edge_detect_macros.svh
// ============================================================================
// Assertion macros for the neighbour difference edge detector
// Shared concurrent assertion forms, clocked and disabled during reset.
// ============================================================================
`ifndef NEIGHBOUR_DIFFERENCE_EDGE_DETECT_MACROS_SVH
`define NEIGHBOUR_DIFFERENCE_EDGE_DETECT_MACROS_SVH

// Same-cycle implication
`define NDE_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("edge detector check failed");

// Next-cycle implication
`define NDE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("edge detector check failed");

`endif

// File: sv/nde_pkg.sv
// ============================================================================
// nde_pkg
// Types, register codes and pixel arithmetic for the edge detector.
// ============================================================================
package nde_pkg;

    // Field and register widths
    localparam int CH_W       = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int DIFF_W     = 10;   // three channel differences, up to 765
    localparam int SUM_W      = 13;   // eight neighbours, up to 6120
    localparam int LVL_W      = SUM_W - 1;

    localparam logic [CH_W-1:0] LEVEL_MAX        = 8'd255;
    localparam logic [CH_W-1:0] THRESHOLD_RESET  = 8'd0;
    localparam logic [CH_W-1:0] EDGE_VALUE_RESET = 8'd255;
    localparam int              FRAME_DIM_RESET  = 1024;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2,
        CFG_EDGE_VALUE   = 2'd3
    } cfg_index_t;

    // Request opcodes
    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    function automatic logic [CH_W-1:0] abs_diff(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Sum of absolute channel differences between two pixels
    function automatic logic [DIFF_W-1:0] pixel_diff(input pixel_t p, input pixel_t q);
        logic [DIFF_W-1:0] d;
        d = DIFF_W'(abs_diff(p.red, q.red))
          + DIFF_W'(abs_diff(p.green, q.green))
          + DIFF_W'(abs_diff(p.blue, q.blue));
        return d;
    endfunction

endpackage

// File: sv/neighbour_difference_edge_detect.sv
// A result leaves on the output register, through stage 1 and stage 2, after the request that
// completes its 3x3 neighbourhood is accepted, i.e. frame_width+1 requests after its pixel.
// Throughput: 1 request per cycle unless the output stalls; set by the single read/write port pair of each line store.
// Reset: counters and pipeline valids clear, registers load 1024, 1024, 0, 255.
// Line stores are not cleared; entries not yet written in a frame feed only masked differences.
// ============================================================================
// neighbour_difference_edge_detect
// Streaming RGB edge detector: sum of absolute differences to the in-frame
// 8-neighbours, halved and saturated, then graded or thresholded output.
// ============================================================================
module neighbour_difference_edge_detect #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Input channel
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             opcode,
    input  logic [nde_pkg::CH_W-1:0]         red,
    input  logic [nde_pkg::CH_W-1:0]         green,
    input  logic [nde_pkg::CH_W-1:0]         blue,
    // Output channel
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [nde_pkg::CH_W-1:0]         edge_level,
    output logic                             frame_end,
    // Configuration write port
    input  logic                             cfg_write,
    input  logic [nde_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nde_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import nde_pkg::*;

    localparam int WW  = $clog2(MAX_WIDTH + 1);    // holds MAX_WIDTH
    localparam int HW  = $clog2(MAX_HEIGHT + 1);   // holds MAX_HEIGHT
    localparam int CB  = $clog2(MAX_WIDTH);        // column index
    localparam int RB  = $clog2(MAX_HEIGHT + 2);   // row count up to height+1
    localparam int RB1 = RB + 1;
    localparam int FWC = (WW > FW_W) ? WW : FW_W;
    localparam int FHC = (HW > FH_W) ? HW : FH_W;
    localparam int WIDTH_RESET  = (MAX_WIDTH < FRAME_DIM_RESET) ? MAX_WIDTH : FRAME_DIM_RESET;
    localparam int HEIGHT_RESET = (MAX_HEIGHT < FRAME_DIM_RESET) ? MAX_HEIGHT : FRAME_DIM_RESET;

    // Configuration registers
    logic [WW-1:0]   width_reg;
    logic [HW-1:0]   height_reg;
    logic [CH_W-1:0] threshold_reg;
    logic [CH_W-1:0] edge_value_reg;
    logic [WW-1:0]   width_next;
    logic [HW-1:0]   height_next;
    logic [FWC-1:0]  width_in;
    logic [FHC-1:0]  height_in;
    logic            size_write;

    // Input position
    logic [CB-1:0]   col_reg;
    logic [RB-1:0]   row_reg;
    logic [CB-1:0]   col_next;
    logic [RB-1:0]   row_next;

    // Line stores
    pixel_t          upper_mem [0:MAX_WIDTH-1];
    pixel_t          lower_mem [0:MAX_WIDTH-1];
    pixel_t          upper_rd_reg;
    pixel_t          lower_rd_reg;
    pixel_t          prev_mid_reg;

    // Stage 1: line store data returned, window shift
    logic            s1_valid_reg;
    logic            s1_res_reg;
    logic            s1_fe_reg;
    logic            s1_top_out_reg;
    logic            s1_bot_out_reg;
    logic            s1_left_out_reg;
    logic            s1_right_out_reg;
    logic            s1_fwd_reg;
    logic [CB-1:0]   s1_col_reg;
    pixel_t          s1_pix_reg;

    // Stage 2: masked neighbour differences
    logic            s2_valid_reg;
    logic            s2_fe_reg;
    logic [DIFF_W-1:0] s2_diff_reg [0:2][0:2];

    // Output register
    logic            out_valid_reg;
    logic [CH_W-1:0] edge_level_reg;
    logic            frame_end_reg;

    // Window
    pixel_t          win_reg [0:2][0:2];
    pixel_t          win_next [0:2][0:2];
    logic [DIFF_W-1:0] diff_next [0:2][0:2];

    // Handshake and stage control
    logic            in_accept;
    logic            out_ready;
    logic            s2_leave;
    logic            s1_leave;
    logic            s1_ready;
    logic            load_s1;

    // Stage 0 decode
    logic            complete;
    logic            active;
    logic            col_nz;
    logic            has_result;
    logic [RB-1:0]   center_row;
    logic            top_out;
    logic            bot_out;
    logic            left_out;
    logic            right_out;
    logic            fe_now;
    logic [WW-1:0]   col_inc;
    pixel_t          pix_in;

    // Stage 1 data
    pixel_t          top_pix;
    pixel_t          mid_pix;

    // Stage 2 arithmetic
    logic [SUM_W-1:0] row_sum [0:2];
    logic [SUM_W-1:0] total;
    logic [LVL_W-1:0] level_half;
    logic [CH_W-1:0]  level_sat;
    logic [CH_W-1:0]  level_out;

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    assign out_ready = !out_valid_reg || !out_stall;
    assign s2_leave  = s2_valid_reg && out_ready;
    assign s1_leave  = s1_valid_reg && (!s1_res_reg || !s2_valid_reg || out_ready);
    assign s1_ready  = !s1_valid_reg || s1_leave;
    assign in_stall  = !s1_ready;
    assign in_accept = in_valid && s1_ready;
    assign load_s1   = in_accept && active;

    // ------------------------------------------------------------------
    // Register write clamping
    // ------------------------------------------------------------------
    always_comb
    begin
        width_in  = FWC'(cfg_data[FW_W-1:0]);
        height_in = FHC'(cfg_data[FH_W-1:0]);
        if (width_in == '0)
            width_next = WW'(1);
        else if (width_in > FWC'(MAX_WIDTH))
            width_next = WW'(MAX_WIDTH);
        else
            width_next = WW'(width_in);
        if (height_in == '0)
            height_next = HW'(1);
        else if (height_in > FHC'(MAX_HEIGHT))
            height_next = HW'(MAX_HEIGHT);
        else
            height_next = HW'(height_in);
    end

    assign size_write = cfg_write && ((cfg_index_t'(cfg_index) == CFG_FRAME_WIDTH) ||
                                      (cfg_index_t'(cfg_index) == CFG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg      <= WW'(WIDTH_RESET);
            height_reg     <= HW'(HEIGHT_RESET);
            threshold_reg  <= THRESHOLD_RESET;
            edge_value_reg <= EDGE_VALUE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_FRAME_WIDTH:  width_reg      <= width_next;
                CFG_FRAME_HEIGHT: height_reg     <= height_next;
                CFG_THRESHOLD:    threshold_reg  <= cfg_data[CH_W-1:0];
                CFG_EDGE_VALUE:   edge_value_reg <= cfg_data[CH_W-1:0];
                default:          ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage 0: position decode for the accepted request
    // ------------------------------------------------------------------
    always_comb
    begin
        complete   = row_reg >= RB'(height_reg);
        active     = !((opcode_t'(opcode) == OP_DRAIN) && !complete);
        pix_in     = complete ? pixel_t'('0) : pixel_t'({red, green, blue});
        col_nz     = col_reg != '0;
        // Centre is one row up and one column back, or the last column two rows up
        has_result = col_nz ? (row_reg != '0) : (row_reg > RB'(1));
        center_row = col_nz ? (row_reg - RB'(1)) : (row_reg - RB'(2));
        top_out    = center_row == '0;
        bot_out    = (RB1'(center_row) + RB1'(1)) >= RB1'(height_reg);
        left_out   = (col_reg == CB'(1)) || (!col_nz && (width_reg == WW'(1)));
        right_out  = !col_nz;
        fe_now     = has_result && bot_out && right_out;
        col_inc    = WW'(col_reg) + WW'(1);
        if (fe_now)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (col_inc >= width_reg)
        begin
            col_next = '0;
            row_next = row_reg + RB'(1);
        end
        else
        begin
            col_next = col_inc[CB-1:0];
            row_next = row_reg;
        end
    end

    // Position counters; a size write restarts the frame
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (size_write)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (load_s1)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ------------------------------------------------------------------
    // Line stores: lower written on accept, upper when stage 1 retires
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            lower_mem[col_reg] <= pix_in;
            lower_rd_reg       <= lower_mem[col_reg];
            upper_rd_reg       <= upper_mem[col_reg];
        end
        if (s1_leave)
            upper_mem[s1_col_reg] <= mid_pix;
    end

    // ------------------------------------------------------------------
    // Stage 1 registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (load_s1)
            s1_valid_reg <= 1'b1;
        else if (s1_leave)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load_s1)
        begin
            s1_res_reg       <= has_result;
            s1_fe_reg        <= fe_now;
            s1_top_out_reg   <= top_out;
            s1_bot_out_reg   <= bot_out;
            s1_left_out_reg  <= left_out;
            s1_right_out_reg <= right_out;
            // Upper store write of the retiring request lands too late for this read
            s1_fwd_reg       <= s1_valid_reg && (s1_col_reg == col_reg);
            s1_col_reg       <= col_reg;
            s1_pix_reg       <= pix_in;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 logic: new window and masked differences to the centre
    // ------------------------------------------------------------------
    assign top_pix = s1_fwd_reg ? prev_mid_reg : upper_rd_reg;
    assign mid_pix = lower_rd_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i][0] = win_reg[i][1];
            win_next[i][1] = win_reg[i][2];
        end
        win_next[0][2] = top_pix;
        win_next[1][2] = mid_pix;
        win_next[2][2] = s1_pix_reg;

        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                if ((i == 1 && j == 1) ||
                    (i == 0 && s1_top_out_reg) || (i == 2 && s1_bot_out_reg) ||
                    (j == 0 && s1_left_out_reg) || (j == 2 && s1_right_out_reg))
                    diff_next[i][j] = '0;
                else
                    diff_next[i][j] = pixel_diff(win_next[i][j], win_next[1][1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_leave)
        begin
            win_reg      <= win_next;
            prev_mid_reg <= mid_pix;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (s1_leave && s1_res_reg)
            s2_valid_reg <= 1'b1;
        else if (s2_leave)
            s2_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_leave && s1_res_reg)
        begin
            s2_diff_reg <= diff_next;
            s2_fe_reg   <= s1_fe_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 logic: sum, halve, saturate, classify
    // ------------------------------------------------------------------
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            row_sum[i] = SUM_W'(s2_diff_reg[i][0]) + SUM_W'(s2_diff_reg[i][1])
                       + SUM_W'(s2_diff_reg[i][2]);
        total      = row_sum[0] + row_sum[1] + row_sum[2];
        level_half = total[SUM_W-1:1];
        level_sat  = (level_half > LVL_W'(LEVEL_MAX)) ? LEVEL_MAX : level_half[CH_W-1:0];
        if (threshold_reg == '0)
            level_out = level_sat;
        else
            level_out = (level_sat > threshold_reg) ? edge_value_reg : '0;
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s2_leave)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s2_leave)
        begin
            edge_level_reg <= level_out;
            frame_end_reg  <= s2_fe_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_level = edge_level_reg;
    assign frame_end  = frame_end_reg;

endmodule

// File: sv/nde_checker.sv
// ============================================================================
// nde_checker
// Port-level checks on the edge detector, bound to the top level.
// ============================================================================
`include "neighbour_difference_edge_detect_macros.svh"

module nde_checker (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_stall,
    input  logic                             out_valid,
    input  logic                             out_stall,
    input  logic [nde_pkg::CH_W-1:0]         edge_level,
    input  logic                             frame_end,
    input  logic                             cfg_write,
    input  logic [nde_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [nde_pkg::CFG_DATA_W-1:0]   cfg_data
);

    import nde_pkg::*;

    logic [CH_W-1:0] threshold_reg;
    logic [CH_W-1:0] edge_value_reg;
    logic            in_pending;

    // Shadow copies of the classification registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= THRESHOLD_RESET;
            edge_value_reg <= EDGE_VALUE_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index_t'(cfg_index) == CFG_THRESHOLD)
                threshold_reg <= cfg_data[CH_W-1:0];
            if (cfg_index_t'(cfg_index) == CFG_EDGE_VALUE)
                edge_value_reg <= cfg_data[CH_W-1:0];
        end
    end

    assign in_pending = in_valid && in_stall;

    // An empty output register never holds back the input
    `NDE_ASSERT_IMPLY(a_no_stall_when_out_empty, clk, rst_n, !out_valid, !in_stall)

    // Binary mode gives only zero or the edge value
    `NDE_ASSERT_IMPLY(a_binary_levels, clk, rst_n, out_valid && (threshold_reg != '0), (edge_level == '0) || (edge_level == edge_value_reg))

    // A stalled request holds its result
    `NDE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(edge_level) && $stable(frame_end))

    // Input stall is only raised behind a stalled full output
    `NDE_ASSERT_IMPLY(a_stall_needs_out_stall, clk, rst_n, in_pending, out_valid && out_stall)

endmodule

bind neighbour_difference_edge_detect nde_checker u_nde_checker (.*);
